>>> rtl/adsr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the adsr envelope generator
// no dependencies; imported by the controller, datapath and top level

package adsr_pkg;

    localparam int VOICE_W = 6;
    localparam int LEVEL_W = 15;
    localparam int CLOCK_W = 23;
    localparam int WORD_W  = 16;
    localparam int PHASE_W = 3;

    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_KEY_ON  = 2'd1;
    localparam logic [1:0] FUNC_KEY_OFF = 2'd2;

    localparam logic [PHASE_W-1:0] PH_OFF     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    localparam logic [1:0] ST_SILENT    = 2'd0;
    localparam logic [1:0] ST_SOUNDING  = 2'd1;
    localparam logic [1:0] ST_RELEASING = 2'd2;
    localparam logic [1:0] ST_KEYED_LOW = 2'd3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7FFF;
    localparam logic [LEVEL_W-1:0] EXP_KNEE  = 15'h6000;
    localparam int                 SUSTAIN_SHIFT = 11;
    localparam logic [4:0]         SHIFT_BASE    = 5'd11;
    localparam logic signed [4:0]  DELTA_DOWN    = -5'sd8;
    localparam logic signed [4:0]  DELTA_UP      = 5'sd7;

    typedef struct packed {
        logic [WORD_W-1:0]  sr;
        logic [WORD_W-1:0]  ad;
        logic               active;
        logic [CLOCK_W-1:0] clock;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
    } voice_state_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic update;
        logic push;
    } adsr_cmd_t;

endpackage

>>> rtl/adsr_ctrl.sv
`timescale 1ns / 1ps
// sequencing controller: accept, compute, write back, push result
// depends on adsr_pkg for the command struct

module adsr_ctrl
    import adsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    output logic      m_axis_tvalid,
    input  logic      m_axis_tready,
    output adsr_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       accept;
    logic       push;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = (state_reg == S_PUSH) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;

    assign cmd.load   = accept;
    assign cmd.calc   = (state_reg == S_CALC);
    assign cmd.update = (state_reg == S_UPD);
    assign cmd.push   = push;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (push)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (push)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/adsr_datapath.sv
`timescale 1ns / 1ps
// per-voice state memory, envelope step arithmetic and result register
// depends on adsr_pkg; driven by adsr_ctrl commands

module adsr_datapath
    import adsr_pkg::*;
#(
    parameter int VOICES = 48
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  adsr_cmd_t          cmd,
    input  logic [1:0]         in_func,
    input  logic [VOICE_W-1:0] in_voice,
    input  logic [WORD_W-1:0]  in_ad,
    input  logic [WORD_W-1:0]  in_sr,
    output logic [VOICE_W-1:0] voice_out,
    output logic [LEVEL_W-1:0] level,
    output logic [PHASE_W-1:0] phase,
    output logic               active,
    output logic [1:0]         status
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    voice_state_t mem [VOICES];
    logic [VOICES-1:0] valid_reg;

    // latched transaction
    logic [1:0]         func_reg;
    logic [VOICE_W-1:0] voice_reg;
    logic [WORD_W-1:0]  ad_in_reg;
    logic [WORD_W-1:0]  sr_in_reg;
    logic               in_range_reg;
    logic               vld_rd_reg;
    voice_state_t       rd_reg;
    logic               in_range;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    voice_state_t       cur;

    // step calculation
    logic [4:0]          sh;
    logic [1:0]          sub;
    logic                down;
    logic                expo;
    logic                has_env;
    logic [4:0]          period_sh;
    logic [4:0]          period_sh_eff;
    logic [CLOCK_W-1:0]  period;
    logic [CLOCK_W-1:0]  clk_inc;
    logic [3:0]          mul_sh;
    logic signed [4:0]   base;
    logic [15:0]         delta;
    logic signed [31:0]  prod_full;

    logic                step_due_reg;
    logic [CLOCK_W-1:0]  clk_inc_reg;
    logic [15:0]         delta_reg;
    logic signed [30:0]  prod_reg;
    logic                expo_down_reg;
    logic                has_env_reg;

    // write back
    logic [15:0]          delta_eff;
    logic signed [16:0]   sum;
    logic [LEVEL_W-1:0]   clamped;
    logic [15:0]          target;
    voice_state_t         nxt;
    voice_state_t         nxt_reg;
    logic [1:0]           st;

    logic [VOICE_W-1:0]   voice_out_reg;
    logic [LEVEL_W-1:0]   level_out_reg;
    logic [PHASE_W-1:0]   phase_out_reg;
    logic                 active_out_reg;
    logic [1:0]           status_out_reg;

    assign in_range = ({1'b0, in_voice} < 7'(VOICES));
    assign rd_addr  = in_voice[AW-1:0];
    assign wr_addr  = voice_reg[AW-1:0];
    assign cur      = vld_rd_reg ? rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            voice_reg <= in_voice;
            ad_in_reg <= in_ad;
            sr_in_reg <= in_sr;
            if (in_range)
            begin
                rd_reg <= mem[rd_addr];
            end
        end
        if (cmd.update && in_range_reg)
        begin
            mem[wr_addr] <= nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            vld_rd_reg   <= 1'b0;
            in_range_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                in_range_reg <= in_range;
                vld_rd_reg   <= in_range && valid_reg[rd_addr];
            end
            if (cmd.update && in_range_reg)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // phase decode
    always_comb
    begin
        sh      = 5'd0;
        sub     = 2'd0;
        down    = 1'b0;
        expo    = 1'b0;
        has_env = 1'b1;
        case (cur.phase)
            PH_ATTACK:
            begin
                sh   = cur.ad[14:10];
                sub  = cur.ad[9:8];
                expo = cur.ad[15];
            end
            PH_DECAY:
            begin
                sh   = {1'b0, cur.ad[7:4]};
                down = 1'b1;
                expo = 1'b1;
            end
            PH_SUSTAIN:
            begin
                sh   = cur.sr[12:8];
                sub  = cur.sr[7:6];
                down = cur.sr[14];
                expo = cur.sr[15];
            end
            PH_RELEASE:
            begin
                sh   = cur.sr[4:0];
                down = 1'b1;
                expo = cur.sr[5];
            end
            default:
            begin
                has_env = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        period_sh     = (sh > SHIFT_BASE) ? (sh - SHIFT_BASE) : 5'd0;
        period_sh_eff = (expo && !down && (cur.level > EXP_KNEE)) ? (period_sh + 5'd2)
                                                                   : period_sh;
        period        = CLOCK_W'(1) << period_sh_eff;
        clk_inc       = cur.clock + CLOCK_W'(1);
        mul_sh        = (sh < SHIFT_BASE) ? 4'(SHIFT_BASE - sh) : 4'd0;
        base          = down ? (DELTA_DOWN + $signed({3'b000, sub}))
                             : (DELTA_UP - $signed({3'b000, sub}));
        delta         = {{11{base[4]}}, base} << mul_sh;
        prod_full     = $signed(delta) * $signed({1'b0, cur.level});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            step_due_reg  <= (clk_inc >= period);
            clk_inc_reg   <= clk_inc;
            delta_reg     <= delta;
            prod_reg      <= prod_full[30:0];
            expo_down_reg <= expo && down;
            has_env_reg   <= has_env;
        end
    end

    // level update, clamp, phase transitions and key-on / key-off handling
    always_comb
    begin
        delta_eff = expo_down_reg ? prod_reg[30:15] : delta_reg;
        sum       = $signed({2'b00, cur.level}) + $signed({delta_eff[15], delta_eff});
        if (sum[16])
        begin
            clamped = '0;
        end
        else if (sum[15])
        begin
            clamped = LEVEL_MAX;
        end
        else
        begin
            clamped = sum[14:0];
        end
        target = 16'(({1'b0, cur.ad[3:0]} + 5'd1)) << SUSTAIN_SHIFT;

        nxt = cur;
        case (func_reg)
            FUNC_TICK:
            begin
                if (cur.active && has_env_reg)
                begin
                    if (!step_due_reg)
                    begin
                        nxt.clock = clk_inc_reg;
                    end
                    else
                    begin
                        nxt.clock = '0;
                        nxt.level = clamped;
                        if ((cur.phase == PH_ATTACK) && (clamped == LEVEL_MAX))
                        begin
                            nxt.phase = PH_DECAY;
                        end
                        else if ((cur.phase == PH_DECAY) && ({1'b0, clamped} <= target))
                        begin
                            nxt.phase = PH_SUSTAIN;
                        end
                        else if ((cur.phase == PH_RELEASE) && (clamped == '0))
                        begin
                            nxt.phase  = PH_OFF;
                            nxt.active = 1'b0;
                        end
                    end
                end
            end
            FUNC_KEY_ON:
            begin
                nxt.sr     = sr_in_reg;
                nxt.ad     = ad_in_reg;
                nxt.active = 1'b1;
                nxt.clock  = '0;
                nxt.level  = '0;
                nxt.phase  = PH_ATTACK;
            end
            FUNC_KEY_OFF:
            begin
                if (cur.active && (cur.phase != PH_RELEASE))
                begin
                    nxt.phase = PH_RELEASE;
                    nxt.clock = '0;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            nxt_reg <= nxt;
        end
    end

    always_comb
    begin
        if (!nxt_reg.active)
        begin
            st = ST_SILENT;
        end
        else if (nxt_reg.phase == PH_RELEASE)
        begin
            st = (nxt_reg.level != '0) ? ST_RELEASING : ST_SILENT;
        end
        else
        begin
            st = (nxt_reg.level != '0) ? ST_SOUNDING : ST_KEYED_LOW;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            voice_out_reg  <= voice_reg;
            level_out_reg  <= in_range_reg ? nxt_reg.level : '0;
            phase_out_reg  <= in_range_reg ? nxt_reg.phase : PH_OFF;
            active_out_reg <= in_range_reg && nxt_reg.active;
            status_out_reg <= in_range_reg ? st : ST_SILENT;
        end
    end

    assign voice_out = voice_out_reg;
    assign level     = level_out_reg;
    assign phase     = phase_out_reg;
    assign active    = active_out_reg;
    assign status    = status_out_reg;

endmodule

>>> rtl/adsr_envelope_generator_top.sv
`timescale 1ns / 1ps
// top level of the per-voice adsr envelope generator
// depends on adsr_pkg, adsr_ctrl and adsr_datapath
//
// channel   | direction | fields
// ----------+-----------+---------------------------------------------------
// s_axis    | in        | tuser: func; tdata: voice, ad word, sr word
// m_axis    | out       | tdata: voice_out, level, phase, active, status
//
// each transaction runs through acceptance with the state memory read, step
// arithmetic with its multiplier, write-back, then the push into the output register
// the result enters the output register at the push, after the calc and update states,
// and the next transaction is accepted only once the controller is back in idle
// one transaction is in flight at a time; a new one is taken while a result
// still waits in the output register, and a stalled output holds the push
// reset clears the per-voice valid flags, so every voice reads as silent

module adsr_envelope_generator_top
    import adsr_pkg::*;
#(
    parameter int VOICES = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // voice[5:0], attack_decay_word[21:6], sustain_release_word[37:22]
    input  logic [1:0]  s_axis_tuser,  // func[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // voice_out[5:0], level[20:6], phase[23:21], active[24], status[26:25]
);

    adsr_cmd_t          cmd;
    logic [VOICE_W-1:0] voice_out;
    logic [LEVEL_W-1:0] level;
    logic [PHASE_W-1:0] phase;
    logic               active;
    logic [1:0]         status;

    adsr_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cmd           (cmd)
    );

    adsr_datapath #(
        .VOICES (VOICES)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_func   (s_axis_tuser),
        .in_voice  (s_axis_tdata[5:0]),
        .in_ad     (s_axis_tdata[21:6]),
        .in_sr     (s_axis_tdata[37:22]),
        .voice_out (voice_out),
        .level     (level),
        .phase     (phase),
        .active    (active),
        .status    (status)
    );

    assign m_axis_tdata = {5'd0, status, active, phase, level, voice_out};

`ifndef SYNTHESIS
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a transaction is in flight");

    a_silent_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !active |-> (level == '0) && (phase == PH_OFF))
        else $error("inactive voice reports a level or phase");

    a_phase_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (phase != PH_OFF) |-> active)
        else $error("voice in an envelope phase is not active");

    a_keyed_low: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (status == ST_KEYED_LOW) |-> (level == '0) && active)
        else $error("keyed at zero status with nonzero level");
`endif

endmodule

>>> tb/tb_adsr_envelope_generator_top.sv
`timescale 1ns / 1ps
// self-checking testbench for adsr_envelope_generator_top: a directed table, then random
// tick / key-on / key-off traffic with random stalls on both streams, checked by a predictor
// depends on adsr_pkg and the rtl of adsr_envelope_generator_top

module tb_adsr_envelope_generator_top;
    import adsr_pkg::*;

    localparam int VOICES        = 48;
    localparam int RANDOM_ITEMS  = 600;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic               active;
        logic [1:0]         status;
    } envelope_result_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [VOICE_W-1:0] voice;
        logic [WORD_W-1:0] ad;
        logic [WORD_W-1:0] sr;
        logic              typed;
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase;
        logic              active;
        logic [1:0]        status;
    } stim_row_t;

    localparam int ROWS = 26;

    // rows with typed = 1 carry an expected result read straight off the behaviour
    stim_row_t directed_rows [ROWS] = '{
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b1, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_KEY_OFF, 6'd5,  16'h0000, 16'h0000, 1'b1, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_KEY_ON,  6'd63, 16'hFFFF, 16'hFFFF, 1'b1, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_UNUSED,  6'd47, 16'hFFFF, 16'hFFFF, 1'b1, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_KEY_ON,  6'd47, 16'hFFFF, 16'hFFFF, 1'b1, 15'd0, PH_ATTACK,  1'b1, ST_KEYED_LOW},
        '{FUNC_TICK,    6'd47, 16'h0000, 16'h0000, 1'b1, 15'd0, PH_ATTACK,  1'b1, ST_KEYED_LOW},
        '{FUNC_KEY_OFF, 6'd47, 16'h0000, 16'h0000, 1'b1, 15'd0, PH_RELEASE, 1'b1, ST_SILENT},
        '{FUNC_KEY_OFF, 6'd47, 16'h0000, 16'h0000, 1'b1, 15'd0, PH_RELEASE, 1'b1, ST_SILENT},
        '{FUNC_UNUSED,  6'd47, 16'h0000, 16'h0000, 1'b1, 15'd0, PH_RELEASE, 1'b1, ST_SILENT},
        '{FUNC_KEY_ON,  6'd0,  16'h0000, 16'h0000, 1'b1, 15'd0, PH_ATTACK,  1'b1, ST_KEYED_LOW},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_KEY_OFF, 6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd0,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_KEY_ON,  6'd1,  16'h8400, 16'hC0A1, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd1,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd1,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT},
        '{FUNC_TICK,    6'd1,  16'h0000, 16'h0000, 1'b0, 15'd0, PH_OFF,     1'b0, ST_SILENT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // voice, attack_decay_word, sustain_release_word
    logic [1:0]  s_axis_tuser = '0;  // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // voice_out, level, phase, active, status

    logic [PHASE_W-1:0] env_phase      [VOICES];
    logic [LEVEL_W-1:0] env_level      [VOICES];
    logic [CLOCK_W-1:0] env_rate_count [VOICES];
    logic               env_active     [VOICES];
    logic [WORD_W-1:0]  env_ad         [VOICES];
    logic [WORD_W-1:0]  env_sr         [VOICES];

    envelope_result_t expected_results [$];
    int error_count = 0;
    int cycle_count = 0;
    bit stalls_on   = 1'b1;

    adsr_envelope_generator_top #(.VOICES(VOICES)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        for (int i = 0; i < VOICES; i++)
        begin
            env_phase[i]      = PH_OFF;
            env_level[i]      = '0;
            env_rate_count[i] = '0;
            env_active[i]     = 1'b0;
            env_ad[i]         = '0;
            env_sr[i]         = '0;
        end
    end

    // envelope predictor: applies one transaction to the shadow voice bank
    task automatic envelope_step(input logic [1:0] func, input logic [VOICE_W-1:0] voice,
                                 input logic [WORD_W-1:0] ad, input logic [WORD_W-1:0] sr,
                                 output envelope_result_t res);
        int v;
        int shi;
        int sub;
        int base;
        int delta;
        int lvl;
        int target;
        int unsigned period;
        bit down;
        bit expo;
        bit stepping;
        logic [CLOCK_W-1:0] clk_next;
        res = '0;
        res.voice = voice;
        base = SHIFT_BASE;
        if (voice < VOICES)
        begin
            v = voice;
            case (func)
                FUNC_TICK:
                begin
                    if (env_active[v])
                    begin
                        stepping = 1'b1;
                        sub = 0;
                        shi = 0;
                        down = 1'b0;
                        expo = 1'b0;
                        lvl = env_level[v];
                        target = (int'(env_ad[v][3:0]) + 1) << SUSTAIN_SHIFT;
                        case (env_phase[v])
                            PH_ATTACK:
                            begin
                                shi = env_ad[v][14:10];
                                sub = env_ad[v][9:8];
                                expo = env_ad[v][15];
                            end
                            PH_DECAY:
                            begin
                                shi = env_ad[v][7:4];
                                down = 1'b1;
                                expo = 1'b1;
                            end
                            PH_SUSTAIN:
                            begin
                                shi = env_sr[v][12:8];
                                sub = env_sr[v][7:6];
                                down = env_sr[v][14];
                                expo = env_sr[v][15];
                            end
                            PH_RELEASE:
                            begin
                                shi = env_sr[v][4:0];
                                down = 1'b1;
                                expo = env_sr[v][5];
                            end
                            default: stepping = 1'b0;
                        endcase
                        if (stepping)
                        begin
                            period = 1 << ((shi > base) ? shi - base : 0);
                            delta = down ? int'(DELTA_DOWN) + sub : int'(DELTA_UP) - sub;
                            delta = delta * (1 << ((shi < base) ? base - shi : 0));
                            if (expo && !down && lvl > int'(EXP_KNEE))
                                period = period * 4;
                            clk_next = env_rate_count[v] + 1'b1;
                            if (clk_next < period)
                                env_rate_count[v] = clk_next;
                            else
                            begin
                                env_rate_count[v] = '0;
                                // arithmetic shift of a signed product floors toward minus infinity
                                if (expo && down)
                                    delta = (delta * lvl) >>> 15;
                                lvl = lvl + delta;
                                if (lvl < 0)
                                    lvl = 0;
                                if (lvl > int'(LEVEL_MAX))
                                    lvl = int'(LEVEL_MAX);
                                env_level[v] = lvl[LEVEL_W-1:0];
                                if (env_phase[v] == PH_ATTACK && lvl == int'(LEVEL_MAX))
                                    env_phase[v] = PH_DECAY;
                                else if (env_phase[v] == PH_DECAY && lvl <= target)
                                    env_phase[v] = PH_SUSTAIN;
                                else if (env_phase[v] == PH_RELEASE && lvl == 0)
                                begin
                                    env_phase[v] = PH_OFF;
                                    env_active[v] = 1'b0;
                                end
                            end
                        end
                    end
                end
                FUNC_KEY_ON:
                begin
                    env_ad[v] = ad;
                    env_sr[v] = sr;
                    env_phase[v] = PH_ATTACK;
                    env_level[v] = '0;
                    env_rate_count[v] = '0;
                    env_active[v] = 1'b1;
                end
                FUNC_KEY_OFF:
                begin
                    if (env_active[v] && env_phase[v] != PH_RELEASE)
                    begin
                        env_phase[v] = PH_RELEASE;
                        env_rate_count[v] = '0;
                    end
                end
                default: ;
            endcase
            res.level = env_level[v];
            res.phase = env_phase[v];
            res.active = env_active[v];
            if (!env_active[v])
                res.status = ST_SILENT;
            else if (env_phase[v] == PH_RELEASE)
                res.status = (env_level[v] != 0) ? ST_RELEASING : ST_SILENT;
            else
                res.status = (env_level[v] != 0) ? ST_SOUNDING : ST_KEYED_LOW;
        end
    endtask

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!stalls_on || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_transaction(input logic [1:0] func, input logic [VOICE_W-1:0] voice,
                                    input logic [WORD_W-1:0] ad, input logic [WORD_W-1:0] sr,
                                    input bit typed, input envelope_result_t typed_res);
        envelope_result_t pred;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {2'b00, sr, ad, voice};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        envelope_step(func, voice, ad, sr, pred);
        expected_results.push_back(typed ? typed_res : pred);
        repeat (idle_len()) @(negedge clk) s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // sink side: bursts of ready broken by stalls
    initial
    begin
        int unsigned run;
        forever
        begin
            run = $urandom_range(1, 12);
            repeat (run) @(negedge clk) m_axis_tready <= 1'b1;
            repeat (idle_len()) @(negedge clk) m_axis_tready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        envelope_result_t got;
        envelope_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.voice  = m_axis_tdata[5:0];
            got.level  = m_axis_tdata[20:6];
            got.phase  = m_axis_tdata[23:21];
            got.active = m_axis_tdata[24];
            got.status = m_axis_tdata[26:25];
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.voice !== want.voice)
                begin
                    $display("%0t: voice_out expected %0d actual %0d", $time, want.voice, got.voice);
                    error_count++;
                end
                if (got.level !== want.level)
                begin
                    $display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
                    error_count++;
                end
                if (got.phase !== want.phase)
                begin
                    $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
                    error_count++;
                end
                if (got.active !== want.active)
                begin
                    $display("%0t: active expected %0d actual %0d", $time, want.active, got.active);
                    error_count++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        envelope_result_t typed_res;
        envelope_result_t none;
        logic [1:0] func;
        logic [VOICE_W-1:0] voice;
        logic [WORD_W-1:0] ad;
        logic [WORD_W-1:0] sr;
        int unsigned r;
        none = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < ROWS; i++)
        begin
            typed_res.voice  = directed_rows[i].voice;
            typed_res.level  = directed_rows[i].level;
            typed_res.phase  = directed_rows[i].phase;
            typed_res.active = directed_rows[i].active;
            typed_res.status = directed_rows[i].status;
            send_transaction(directed_rows[i].func, directed_rows[i].voice, directed_rows[i].ad,
                             directed_rows[i].sr, directed_rows[i].typed, typed_res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every 50 items, pick at random whether the next block runs with stalls
            if (n % 50 == 0)
                stalls_on = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_ITEMS / 2)
                wait_for_drain();
            r = $urandom_range(0, 99);
            if (r < 85)
                voice = VOICE_W'($urandom_range(0, 7));
            else if (r < 93)
                voice = VOICE_W'($urandom_range(0, VOICES - 1));
            else
                voice = VOICE_W'($urandom_range(VOICES, 63));
            ad = WORD_W'($urandom_range(0, 16'hFFFF));
            sr = WORD_W'($urandom_range(0, 16'hFFFF));
            r = $urandom_range(0, 99);
            if (r < 68)
                func = FUNC_TICK;
            else if (r < 80)
            begin
                func = FUNC_KEY_ON;
                // mostly short rates so that envelopes run through every phase
                if ($urandom_range(0, 4) != 0)
                begin
                    ad[14:10] = 5'($urandom_range(0, 12));
                    ad[7:4]   = 4'($urandom_range(0, 11));
                    sr[12:8]  = 5'($urandom_range(0, 12));
                    sr[4:0]   = 5'($urandom_range(0, 12));
                end
            end
            else if (r < 95)
                func = FUNC_KEY_OFF;
            else
                func = FUNC_UNUSED;
            send_transaction(func, voice, ad, sr, 1'b0, none);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/adsr_pkg.sv
rtl/adsr_ctrl.sv
rtl/adsr_datapath.sv
rtl/adsr_envelope_generator_top.sv
tb/tb_adsr_envelope_generator_top.sv
